[rtl/lpc_pkg.sv]
// lpc_pkg: shared types and constants of the leadscrew panel controller
// no dependencies; used by every module of the block

package lpc_pkg;

    localparam int PITCH_W = 12;
    localparam int STEP_W  = 8;
    localparam int LED_W   = 7;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // register indexes on the config port (byte address is 4 * index)
    localparam logic [2:0] REG_PITCH_STEP   = 3'd0;
    localparam logic [2:0] REG_METRIC_MIN   = 3'd1;
    localparam logic [2:0] REG_METRIC_MAX   = 3'd2;
    localparam logic [2:0] REG_IMPERIAL_MIN = 3'd3;
    localparam logic [2:0] REG_IMPERIAL_MAX = 3'd4;

    // motion status codes
    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_STOPPED  = 2'd1;
    localparam logic [1:0] ST_STOPPING = 2'd2;
    localparam logic [1:0] ST_ESTOP    = 2'd3;

    // motion commands
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_STOP = 2'd1;
    localparam logic [1:0] CMD_RUN  = 2'd2;

    // thread plan kinds
    localparam logic [1:0] PLAN_NONE     = 2'd0;
    localparam logic [1:0] PLAN_METRIC   = 2'd1;
    localparam logic [1:0] PLAN_IMPERIAL = 2'd2;

    // display update kinds
    localparam logic [1:0] DISP_NONE     = 2'd0;
    localparam logic [1:0] DISP_IMPERIAL = 2'd1;
    localparam logic [1:0] DISP_METRIC   = 2'd2;
    localparam logic [1:0] DISP_BLANK    = 2'd3;

    // status leds
    localparam logic [LED_W-1:0] LED_STOPPED  = 7'h01;
    localparam logic [LED_W-1:0] LED_STOPPING = 7'h02;
    localparam logic [LED_W-1:0] LED_RUNNING  = 7'h04;
    localparam logic [LED_W-1:0] LED_IMPERIAL = 7'h08;
    localparam logic [LED_W-1:0] LED_METRIC   = 7'h10;
    localparam logic [LED_W-1:0] LED_LEFT     = 7'h20;
    localparam logic [LED_W-1:0] LED_REVERSE  = 7'h40;

    // reset values
    localparam logic [STEP_W-1:0]  RST_PITCH_STEP     = 8'd5;
    localparam logic [PITCH_W-1:0] RST_METRIC_MIN     = 12'd20;
    localparam logic [PITCH_W-1:0] RST_METRIC_MAX     = 12'd2500;
    localparam logic [PITCH_W-1:0] RST_IMPERIAL_MIN   = 12'd10;
    localparam logic [PITCH_W-1:0] RST_IMPERIAL_MAX   = 12'd800;
    localparam logic [PITCH_W-1:0] RST_METRIC_PITCH   = 12'd100;
    localparam logic [PITCH_W-1:0] RST_IMPERIAL_PITCH = 12'd80;

    typedef enum logic {
        THREAD_MM  = 1'b0,
        THREAD_TPI = 1'b1
    } thread_mode_t;

    typedef struct packed {
        logic [STEP_W-1:0]  pitch_step;
        logic [PITCH_W-1:0] metric_min;
        logic [PITCH_W-1:0] metric_max;
        logic [PITCH_W-1:0] imperial_min;
        logic [PITCH_W-1:0] imperial_max;
    } cfg_t;

endpackage

[rtl/leadscrew_panel_controller.sv]
// leadscrew_panel_controller: top level, input register, panel decision logic,
// result register and assertions; depends on lpc_pkg, lpc_regs, lpc_pitch_adj
//
// usage
//   input channel (s_*): one beat per panel poll tick, carrying the motion
//   status and the front-panel switches. result channel (m_*): one beat per
//   input beat with the led bits, motion command, optional thread plan request,
//   optional direction/handedness setting and optional pitch display update.
//   apb port: pitch step and the metric/imperial pitch limits, to be written
//   only while the block has no beat in flight; the block does not enforce
//   this. pready is always high.
// pipeline and throughput
//   an accepted beat is held in the input register, where the decision logic
//   and the pitch step/clamp work on it, and moves into the result register,
//   which drives m_valid, once that slot is free or draining. one beat per
//   cycle sustained while m_ready stays high; the state registers (direction,
//   thread mode, replan flag, two pitches) are written as each beat advances.
// reset
//   aresetn is synchronous, active low. both pipeline registers empty, direction
//   forward, metric mode, replan pending, pitches 1.00 mm and 8.0 tpi, config
//   registers at their defaults.
// stall
//   while m_ready is low the result is held; one more beat is taken into the
//   input register, then s_ready drops until the result drains.

module leadscrew_panel_controller (
    input  logic                       aclk,
    input  logic                       aresetn,
    // config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lpc_pkg::ADDR_W-1:0] paddr,
    input  logic [lpc_pkg::DATA_W-1:0] pwdata,
    output logic [lpc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_motion_status,
    input  logic                       s_sw_forward,
    input  logic                       s_sw_reverse,
    input  logic                       s_sw_leadscrew,
    input  logic                       s_sw_dividing,
    input  logic                       s_sw_left_hand,
    input  logic                       s_sw_right_hand,
    input  logic                       s_sw_metric,
    input  logic                       s_sw_imperial,
    input  logic                       s_sw_increase,
    input  logic                       s_sw_decrease,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lpc_pkg::LED_W-1:0]  m_led_bits,
    output logic [1:0]                 m_motion_command,
    output logic [1:0]                 m_plan_kind,
    output logic [lpc_pkg::PITCH_W-1:0] m_plan_pitch,
    output logic                       m_direction_set,
    output logic                       m_direction_forward,
    output logic                       m_left_handed,
    output logic [1:0]                 m_display_kind,
    output logic [lpc_pkg::PITCH_W-1:0] m_display_pitch
);
    import lpc_pkg::*;

    typedef struct packed {
        logic [1:0] motion_status;
        logic       sw_forward;
        logic       sw_reverse;
        logic       sw_leadscrew;
        logic       sw_dividing;
        logic       sw_left_hand;
        logic       sw_right_hand;
        logic       sw_metric;
        logic       sw_imperial;
        logic       sw_increase;
        logic       sw_decrease;
    } panel_t;

    typedef struct packed {
        logic [LED_W-1:0]   led_bits;
        logic [1:0]         motion_command;
        logic [1:0]         plan_kind;
        logic [PITCH_W-1:0] plan_pitch;
        logic               direction_set;
        logic               direction_forward;
        logic               left_handed;
        logic [1:0]         display_kind;
        logic [PITCH_W-1:0] display_pitch;
    } result_t;

    cfg_t cfg;

    // pipeline registers
    logic    in_valid_reg, in_valid_next;
    panel_t  in_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t res;
    logic    advance;

    // panel state
    logic               dir_forward_reg, dir_forward_next;
    thread_mode_t       thread_mode_reg, thread_mode_next;
    logic               needs_replan_reg, needs_replan_next;
    logic [PITCH_W-1:0] metric_pitch_reg, metric_pitch_next;
    logic [PITCH_W-1:0] imperial_pitch_reg, imperial_pitch_next;

    logic               held;
    logic [PITCH_W-1:0] metric_adj;
    logic [PITCH_W-1:0] imperial_adj;

    lpc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpc_pitch_adj u_metric_adj (
        .cur   (metric_pitch_reg),
        .inc   (in_reg.sw_increase),
        .dec   (in_reg.sw_decrease),
        .step  (cfg.pitch_step),
        .lo    (cfg.metric_min),
        .hi    (cfg.metric_max),
        .pitch (metric_adj)
    );

    lpc_pitch_adj u_imperial_adj (
        .cur   (imperial_pitch_reg),
        .inc   (in_reg.sw_increase),
        .dec   (in_reg.sw_decrease),
        .step  (cfg.pitch_step),
        .lo    (cfg.imperial_min),
        .hi    (cfg.imperial_max),
        .pitch (imperial_adj)
    );

    // handshake: the input register drains whenever the result slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // panel decision logic
    always_comb begin
        res                 = '0;
        dir_forward_next    = dir_forward_reg;
        thread_mode_next    = thread_mode_reg;
        needs_replan_next   = needs_replan_reg;
        metric_pitch_next   = metric_pitch_reg;
        imperial_pitch_next = imperial_pitch_reg;

        // run switch matching the direction currently held
        held = dir_forward_reg ? in_reg.sw_forward : in_reg.sw_reverse;

        case (in_reg.motion_status)
            ST_RUNNING: begin
                res.led_bits = LED_RUNNING;
                if (!held) begin
                    res.motion_command = CMD_STOP;
                end
            end
            ST_STOPPED: begin
                res.led_bits = LED_STOPPED;
                // dividing alone does nothing beyond the led
                if (in_reg.sw_leadscrew) begin
                    if (in_reg.sw_forward || in_reg.sw_reverse) begin
                        // both run switches means forward
                        dir_forward_next = in_reg.sw_forward;
                        if (!in_reg.sw_forward) begin
                            res.led_bits = res.led_bits | LED_REVERSE;
                        end
                        if (needs_replan_reg) begin
                            if (thread_mode_reg == THREAD_MM) begin
                                res.plan_kind  = PLAN_METRIC;
                                res.plan_pitch = metric_pitch_reg;
                            end else begin
                                res.plan_kind  = PLAN_IMPERIAL;
                                res.plan_pitch = imperial_pitch_reg;
                            end
                        end
                        // cleared even when no handedness button is down
                        needs_replan_next = 1'b0;
                        if (in_reg.sw_left_hand || in_reg.sw_right_hand) begin
                            // left hand wins over right
                            if (in_reg.sw_left_hand) begin
                                res.led_bits    = res.led_bits | LED_LEFT;
                                res.left_handed = 1'b1;
                            end
                            res.direction_set     = 1'b1;
                            res.direction_forward = in_reg.sw_forward;
                            res.motion_command    = CMD_RUN;
                        end
                    end else if (in_reg.sw_metric) begin
                        // metric wins when both modes are selected
                        res.led_bits      = res.led_bits | LED_METRIC;
                        metric_pitch_next = metric_adj;
                        if (thread_mode_reg != THREAD_MM || in_reg.sw_increase ||
                            in_reg.sw_decrease) begin
                            needs_replan_next = 1'b1;
                        end
                        res.display_kind  = DISP_METRIC;
                        res.display_pitch = metric_adj;
                        thread_mode_next  = THREAD_MM;
                    end else if (in_reg.sw_imperial) begin
                        res.led_bits        = res.led_bits | LED_IMPERIAL;
                        imperial_pitch_next = imperial_adj;
                        if (thread_mode_reg != THREAD_TPI || in_reg.sw_increase ||
                            in_reg.sw_decrease) begin
                            needs_replan_next = 1'b1;
                        end
                        res.display_kind  = DISP_IMPERIAL;
                        res.display_pitch = imperial_adj;
                        thread_mode_next  = THREAD_TPI;
                    end
                end
            end
            ST_STOPPING: begin
                res.led_bits = LED_STOPPING;
                if (held) begin
                    res.motion_command = CMD_RUN;
                end
            end
            default: begin
                // emergency stop: all three motion leds, display blanked
                res.led_bits     = LED_STOPPED | LED_STOPPING | LED_RUNNING;
                res.display_kind = DISP_BLANK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            dir_forward_reg    <= 1'b1;
            thread_mode_reg    <= THREAD_MM;
            needs_replan_reg   <= 1'b1;
            metric_pitch_reg   <= RST_METRIC_PITCH;
            imperial_pitch_reg <= RST_IMPERIAL_PITCH;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                dir_forward_reg    <= dir_forward_next;
                thread_mode_reg    <= thread_mode_next;
                needs_replan_reg   <= needs_replan_next;
                metric_pitch_reg   <= metric_pitch_next;
                imperial_pitch_reg <= imperial_pitch_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.motion_status <= s_motion_status;
            in_reg.sw_forward    <= s_sw_forward;
            in_reg.sw_reverse    <= s_sw_reverse;
            in_reg.sw_leadscrew  <= s_sw_leadscrew;
            in_reg.sw_dividing   <= s_sw_dividing;
            in_reg.sw_left_hand  <= s_sw_left_hand;
            in_reg.sw_right_hand <= s_sw_right_hand;
            in_reg.sw_metric     <= s_sw_metric;
            in_reg.sw_imperial   <= s_sw_imperial;
            in_reg.sw_increase   <= s_sw_increase;
            in_reg.sw_decrease   <= s_sw_decrease;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_led_bits          = out_reg.led_bits;
    assign m_motion_command    = out_reg.motion_command;
    assign m_plan_kind         = out_reg.plan_kind;
    assign m_plan_pitch        = out_reg.plan_pitch;
    assign m_direction_set     = out_reg.direction_set;
    assign m_direction_forward = out_reg.direction_forward;
    assign m_left_handed       = out_reg.left_handed;
    assign m_display_kind      = out_reg.display_kind;
    assign m_display_pitch     = out_reg.display_pitch;

    // a plan request only comes out of the stopped state
    a_plan_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_plan_kind != PLAN_NONE) |-> m_led_bits[0] && !m_led_bits[2])
        else $error("plan request outside stopped state");

    // a direction setting always goes with a run command
    a_dir_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_direction_set |-> (m_motion_command == CMD_RUN))
        else $error("direction set without run command");

    // issuing a plan clears the replan flag
    a_replan_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (res.plan_kind != PLAN_NONE) |=> !needs_replan_reg)
        else $error("replan flag not cleared after plan request");

    // an empty result slot never stalls the input side
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

[rtl/lpc_regs.sv]
// lpc_regs: apb config registers (pitch step and pitch limits)
// depends on lpc_pkg

module lpc_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lpc_pkg::ADDR_W-1:0] paddr,
    input  logic [lpc_pkg::DATA_W-1:0] pwdata,
    output logic [lpc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output lpc_pkg::cfg_t              cfg
);
    import lpc_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pitch_step   <= RST_PITCH_STEP;
            cfg_reg.metric_min   <= RST_METRIC_MIN;
            cfg_reg.metric_max   <= RST_METRIC_MAX;
            cfg_reg.imperial_min <= RST_IMPERIAL_MIN;
            cfg_reg.imperial_max <= RST_IMPERIAL_MAX;
        end else if (wr_en) begin
            case (index)
                REG_PITCH_STEP:   cfg_reg.pitch_step   <= pwdata[STEP_W-1:0];
                REG_METRIC_MIN:   cfg_reg.metric_min   <= pwdata[PITCH_W-1:0];
                REG_METRIC_MAX:   cfg_reg.metric_max   <= pwdata[PITCH_W-1:0];
                REG_IMPERIAL_MIN: cfg_reg.imperial_min <= pwdata[PITCH_W-1:0];
                REG_IMPERIAL_MAX: cfg_reg.imperial_max <= pwdata[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_PITCH_STEP:   prdata = DATA_W'(cfg_reg.pitch_step);
            REG_METRIC_MIN:   prdata = DATA_W'(cfg_reg.metric_min);
            REG_METRIC_MAX:   prdata = DATA_W'(cfg_reg.metric_max);
            REG_IMPERIAL_MIN: prdata = DATA_W'(cfg_reg.imperial_min);
            REG_IMPERIAL_MAX: prdata = DATA_W'(cfg_reg.imperial_max);
            default:          prdata = '0;
        endcase
    end

endmodule

[rtl/lpc_pitch_adj.sv]
// lpc_pitch_adj: step a pitch up or down, then clamp low limit first, high second
// depends on lpc_pkg

module lpc_pitch_adj (
    input  logic [lpc_pkg::PITCH_W-1:0] cur,
    input  logic                        inc,
    input  logic                        dec,
    input  logic [lpc_pkg::STEP_W-1:0]  step,
    input  logic [lpc_pkg::PITCH_W-1:0] lo,
    input  logic [lpc_pkg::PITCH_W-1:0] hi,
    output logic [lpc_pkg::PITCH_W-1:0] pitch
);
    import lpc_pkg::*;

    localparam int SUM_W = PITCH_W + 2;

    logic signed [SUM_W-1:0] up;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    logic signed [SUM_W-1:0] low_clamped;

    always_comb begin
        up   = $signed({2'b00, cur}) + (inc ? $signed(SUM_W'(step)) : '0);
        sum  = up - (dec ? $signed(SUM_W'(step)) : '0);
        lo_s = $signed({2'b00, lo});
        hi_s = $signed({2'b00, hi});
        low_clamped = (sum < lo_s) ? lo_s : sum;
        // crossed limits end on the high limit
        pitch = (low_clamped > hi_s) ? hi : low_clamped[PITCH_W-1:0];
    end

endmodule

[test/tb_leadscrew_panel_controller.sv]
`timescale 1ns / 1ps
// tb_leadscrew_panel_controller: self-checking bench for the leadscrew panel controller,
// predicts every result beat from its own copy of the panel state and checks it field by field
// depends on lpc_pkg and the leadscrew_panel_controller rtl

module tb_leadscrew_panel_controller;
    import lpc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_TRIGGER  = 100;

    // switch positions inside a beat, in port order
    localparam logic [9:0] SW_NONE  = 10'b0000000000;
    localparam logic [9:0] SW_FWD   = 10'b1000000000;
    localparam logic [9:0] SW_REV   = 10'b0100000000;
    localparam logic [9:0] SW_LEAD  = 10'b0010000000;
    localparam logic [9:0] SW_DIV   = 10'b0001000000;
    localparam logic [9:0] SW_LHAND = 10'b0000100000;
    localparam logic [9:0] SW_RHAND = 10'b0000010000;
    localparam logic [9:0] SW_MET   = 10'b0000001000;
    localparam logic [9:0] SW_IMP   = 10'b0000000100;
    localparam logic [9:0] SW_INC   = 10'b0000000010;
    localparam logic [9:0] SW_DEC   = 10'b0000000001;
    localparam logic [9:0] SW_ALL   = 10'b1111111111;

    typedef struct packed {
        logic [1:0] status;
        logic       fwd;
        logic       rev;
        logic       lead;
        logic       divide;
        logic       lhand;
        logic       rhand;
        logic       met;
        logic       imp;
        logic       inc;
        logic       dec;
    } panel_beat_t;

    typedef struct packed {
        logic [LED_W-1:0]   led;
        logic [1:0]         cmd;
        logic [1:0]         plan_kind;
        logic [PITCH_W-1:0] plan_pitch;
        logic               dir_set;
        logic               dir_fwd;
        logic               left;
        logic [1:0]         disp_kind;
        logic [PITCH_W-1:0] disp_pitch;
    } panel_result_t;

    // dut signals; the inputs are all known from time zero
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [DATA_W-1:0]    pwdata   = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_valid  = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_motion_status = ST_STOPPED;
    logic                 s_sw_forward    = 1'b0;
    logic                 s_sw_reverse    = 1'b0;
    logic                 s_sw_leadscrew  = 1'b0;
    logic                 s_sw_dividing   = 1'b0;
    logic                 s_sw_left_hand  = 1'b0;
    logic                 s_sw_right_hand = 1'b0;
    logic                 s_sw_metric     = 1'b0;
    logic                 s_sw_imperial   = 1'b0;
    logic                 s_sw_increase   = 1'b0;
    logic                 s_sw_decrease   = 1'b0;
    logic                 m_valid;
    logic                 m_ready  = 1'b0;
    logic [LED_W-1:0]     m_led_bits;
    logic [1:0]           m_motion_command;
    logic [1:0]           m_plan_kind;
    logic [PITCH_W-1:0]   m_plan_pitch;
    logic                 m_direction_set;
    logic                 m_direction_forward;
    logic                 m_left_handed;
    logic [1:0]           m_display_kind;
    logic [PITCH_W-1:0]   m_display_pitch;

    leadscrew_panel_controller dut (.*);

    // 2 ns period
    always #1 aclk = ~aclk;

    // bench copy of the config registers and of the panel state
    cfg_t                 cfg = '{pitch_step: RST_PITCH_STEP,
                                  metric_min: RST_METRIC_MIN, metric_max: RST_METRIC_MAX,
                                  imperial_min: RST_IMPERIAL_MIN,
                                  imperial_max: RST_IMPERIAL_MAX};
    logic                 hold_fwd       = 1'b1;
    thread_mode_t         cur_mode       = THREAD_MM;
    logic                 replan_pending = 1'b1;
    logic [PITCH_W-1:0]   metric_val     = RST_METRIC_PITCH;
    logic [PITCH_W-1:0]   imperial_val   = RST_IMPERIAL_PITCH;

    panel_beat_t          pending_beats[$];
    panel_result_t        expected_results[$];
    panel_beat_t          cur_beat;

    int send_idle_pct = 30;
    int recv_idle_pct = 30;
    int err_count     = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_plans       = 0;
    int n_runs        = 0;
    int n_configs     = 1;
    int n_in_stalls   = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    // step a pitch up and/or down, then clamp to the low limit and after that to the high
    // limit, so crossed limits end at the high one
    function automatic logic [PITCH_W-1:0] step_and_clamp(input logic [PITCH_W-1:0] cur,
                                                          input logic up, input logic down,
                                                          input logic [PITCH_W-1:0] lo,
                                                          input logic [PITCH_W-1:0] hi);
        int v;
        int step_i;
        int lo_i;
        int hi_i;
        v      = int'(cur);
        step_i = int'(cfg.pitch_step);
        lo_i   = int'(lo);
        hi_i   = int'(hi);
        if (up) v = v + step_i;
        if (down) v = v - step_i;
        if (v < lo_i) v = lo_i;
        if (v > hi_i) v = hi_i;
        return v[PITCH_W-1:0];
    endfunction

    // decision for one poll tick; updates the bench panel state
    function automatic panel_result_t panel_decide(input panel_beat_t b);
        panel_result_t r;
        logic          held;
        r    = '0;
        held = hold_fwd ? b.fwd : b.rev;
        case (b.status)
            ST_RUNNING: begin
                r.led = LED_RUNNING;
                if (!held) r.cmd = CMD_STOP;
            end
            ST_STOPPED: begin
                r.led = LED_STOPPED;
                if (b.lead) begin
                    if (b.fwd || b.rev) begin
                        // forward wins when both run switches are on
                        hold_fwd = b.fwd;
                        if (!hold_fwd) r.led |= LED_REVERSE;
                        if (replan_pending) begin
                            if (cur_mode == THREAD_MM) begin
                                r.plan_kind  = PLAN_METRIC;
                                r.plan_pitch = metric_val;
                            end else begin
                                r.plan_kind  = PLAN_IMPERIAL;
                                r.plan_pitch = imperial_val;
                            end
                        end
                        replan_pending = 1'b0;
                        if (b.lhand || b.rhand) begin
                            if (b.lhand) begin
                                r.led |= LED_LEFT;
                                r.left = 1'b1;
                            end
                            r.dir_set = 1'b1;
                            r.dir_fwd = hold_fwd;
                            r.cmd     = CMD_RUN;
                        end
                    end else if (b.met) begin
                        r.led |= LED_METRIC;
                        metric_val = step_and_clamp(metric_val, b.inc, b.dec,
                                                    cfg.metric_min, cfg.metric_max);
                        if (cur_mode != THREAD_MM || b.inc || b.dec) replan_pending = 1'b1;
                        r.disp_kind  = DISP_METRIC;
                        r.disp_pitch = metric_val;
                        cur_mode     = THREAD_MM;
                    end else if (b.imp) begin
                        r.led |= LED_IMPERIAL;
                        imperial_val = step_and_clamp(imperial_val, b.inc, b.dec,
                                                      cfg.imperial_min, cfg.imperial_max);
                        if (cur_mode != THREAD_TPI || b.inc || b.dec) replan_pending = 1'b1;
                        r.disp_kind  = DISP_IMPERIAL;
                        r.disp_pitch = imperial_val;
                        cur_mode     = THREAD_TPI;
                    end
                end
            end
            ST_STOPPING: begin
                r.led = LED_STOPPING;
                if (held) r.cmd = CMD_RUN;
            end
            default: begin
                // emergency stop lights all three motion leds and blanks the display
                r.led       = LED_STOPPED | LED_STOPPING | LED_RUNNING;
                r.disp_kind = DISP_BLANK;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    function automatic panel_beat_t random_beat();
        logic [31:0] noise;
        noise = $urandom;
        return noise[$bits(panel_beat_t)-1:0];
    endfunction

    // queue one operator sequence with random content, returns the number of beats added
    function automatic int queue_sequence();
        panel_beat_t b;
        int          kind;
        int          start;
        logic        as_imp;
        logic        up;
        logic        go_fwd;
        start = pending_beats.size();
        kind  = $urandom_range(99);
        if (kind < 35) begin
            // burst of pitch presses in one mode, mostly one way, to reach the limits
            as_imp = 1'($urandom_range(1));
            up     = 1'($urandom_range(1));
            repeat ($urandom_range(1, 24)) begin
                b        = random_beat();
                b.status = ST_STOPPED;
                b.lead   = 1'b1;
                b.fwd    = 1'b0;
                b.rev    = 1'b0;
                b.met    = !as_imp;
                b.imp    = as_imp | b.imp;
                if ($urandom_range(7) != 0) begin
                    b.inc = up;
                    b.dec = !up;
                end
                pending_beats.push_back(b);
            end
        end else if (kind < 75) begin
            // start a run, keep it going, release the switch, ride out the stop
            go_fwd   = 1'($urandom_range(1));
            b        = random_beat();
            b.status = ST_STOPPED;
            b.lead   = 1'b1;
            b.fwd    = go_fwd | ($urandom_range(5) == 0);
            b.rev    = !go_fwd | ($urandom_range(5) == 0);
            if ($urandom_range(7) != 0 && !b.lhand && !b.rhand) b.rhand = 1'b1;
            go_fwd = b.fwd;
            pending_beats.push_back(b);
            repeat ($urandom_range(1, 6)) begin
                b        = random_beat();
                b.status = ST_RUNNING;
                if (go_fwd) b.fwd = 1'b1;
                else b.rev = 1'b1;
                pending_beats.push_back(b);
            end
            b        = random_beat();
            b.status = ST_RUNNING;
            if (go_fwd) b.fwd = 1'b0;
            else b.rev = 1'b0;
            pending_beats.push_back(b);
            repeat ($urandom_range(1, 3)) begin
                b        = random_beat();
                b.status = ST_STOPPING;
                pending_beats.push_back(b);
            end
            b        = random_beat();
            b.status = ST_STOPPED;
            pending_beats.push_back(b);
        end else begin
            // plain noise, any status and any switch combination
            repeat ($urandom_range(1, 4)) pending_beats.push_back(random_beat());
        end
        return pending_beats.size() - start;
    endfunction

    // input side: offer queued beats, keep a beat steady until it is taken,
    // predict each beat at the edge where it is accepted
    always @(posedge aclk) begin : feed_beats
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(panel_decide(cur_beat));
                n_sent++;
                if (expected_results[$].plan_kind != PLAN_NONE) n_plans++;
                if (expected_results[$].cmd == CMD_RUN) n_runs++;
            end
            if (s_valid && !s_ready) begin
                // beat still waiting, payload stays put
                n_in_stalls++;
            end else if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_beat         = pending_beats.pop_front();
                s_valid         <= 1'b1;
                s_motion_status <= cur_beat.status;
                s_sw_forward    <= cur_beat.fwd;
                s_sw_reverse    <= cur_beat.rev;
                s_sw_leadscrew  <= cur_beat.lead;
                s_sw_dividing   <= cur_beat.divide;
                s_sw_left_hand  <= cur_beat.lhand;
                s_sw_right_hand <= cur_beat.rhand;
                s_sw_metric     <= cur_beat.met;
                s_sw_imperial   <= cur_beat.imp;
                s_sw_increase   <= cur_beat.inc;
                s_sw_decrease   <= cur_beat.dec;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: check accepted beats against the oldest prediction, then pick m_ready
    always @(posedge aclk) begin : take_results
        panel_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_checked++;
                if (expected_results.size() == 0) begin
                    $error("result beat arrived with no prediction waiting");
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("led_bits", int'(want.led), int'(m_led_bits));
                    check_field("motion_command", int'(want.cmd), int'(m_motion_command));
                    check_field("plan_kind", int'(want.plan_kind), int'(m_plan_kind));
                    check_field("plan_pitch", int'(want.plan_pitch), int'(m_plan_pitch));
                    check_field("direction_set", int'(want.dir_set), int'(m_direction_set));
                    check_field("direction_forward", int'(want.dir_fwd),
                                int'(m_direction_forward));
                    check_field("left_handed", int'(want.left), int'(m_left_handed));
                    check_field("display_kind", int'(want.disp_kind), int'(m_display_kind));
                    check_field("display_pitch", int'(want.disp_pitch),
                                int'(m_display_pitch));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && pending_beats.size() > HOLD_TRIGGER) begin
                // one long hold-off while the sender keeps offering, fills the pipe
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // block only counts as idle once the queue is empty and every prediction is consumed
    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all five registers over apb: setup cycle, then access cycle
    task automatic program_config(input cfg_t c);
        logic [DATA_W-1:0] value;
        for (int idx = REG_PITCH_STEP; idx <= REG_IMPERIAL_MAX; idx++) begin
            case (3'(idx))
                REG_PITCH_STEP:   value = DATA_W'(c.pitch_step);
                REG_METRIC_MIN:   value = DATA_W'(c.metric_min);
                REG_METRIC_MAX:   value = DATA_W'(c.metric_max);
                REG_IMPERIAL_MIN: value = DATA_W'(c.imperial_min);
                default:          value = DATA_W'(c.imperial_max);
            endcase
            // unused upper data bits carry noise
            if (idx == REG_PITCH_STEP) value[DATA_W-1:STEP_W] = (DATA_W-STEP_W)'($urandom);
            else value[DATA_W-1:PITCH_W] = (DATA_W-PITCH_W)'($urandom);
            @(posedge aclk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {3'(idx), 2'b00};
            pwdata  <= value;
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        cfg = c;
        n_configs++;
    endtask

    task automatic run_phase(input int beats, input int send_pct, input int recv_pct);
        int queued;
        queued        = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (queued < beats) queued += queue_sequence();
        wait_drained();
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.pitch_step   = STEP_W'($urandom_range(1, 255));
        c.metric_min   = PITCH_W'($urandom_range(4095));
        c.metric_max   = PITCH_W'($urandom_range(int'(c.metric_min), 4095));
        c.imperial_min = PITCH_W'($urandom_range(4095));
        c.imperial_max = PITCH_W'($urandom_range(int'(c.imperial_min), 4095));
        return c;
    endfunction

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed pass on the reset config
        pending_beats.push_back({ST_STOPPED, SW_LEAD | SW_MET});
        pending_beats.push_back({ST_STOPPED, SW_LEAD | SW_MET | SW_INC});
        // both pitch buttons: no change but replan still marked
        pending_beats.push_back({ST_STOPPED, SW_LEAD | SW_MET | SW_INC | SW_DEC});
        pending_beats.push_back({ST_STOPPED, SW_LEAD | SW_IMP | SW_DEC});
        // metric beats imperial when both are selected
        pending_beats.push_back({ST_STOPPED, SW_LEAD | SW_MET | SW_IMP});
        pending_beats.push_back({ST_STOPPED, SW_LEAD | SW_FWD | SW_RHAND});
        pending_beats.push_back({ST_RUNNING, SW_FWD});
        pending_beats.push_back({ST_RUNNING, SW_NONE});
        pending_beats.push_back({ST_STOPPING, SW_FWD});
        pending_beats.push_back({ST_STOPPING, SW_REV});
        // reverse with no handedness button: plan flag cleared, no run
        pending_beats.push_back({ST_STOPPED, SW_LEAD | SW_REV});
        pending_beats.push_back({ST_RUNNING, SW_FWD});
        pending_beats.push_back({ST_RUNNING, SW_REV});
        // both run switches and both hands: forward, left hand
        pending_beats.push_back({ST_STOPPED, SW_LEAD | SW_FWD | SW_REV | SW_LHAND | SW_RHAND});
        // dividing without leadscrew does nothing beyond the led
        pending_beats.push_back({ST_STOPPED, SW_DIV});
        pending_beats.push_back({ST_STOPPED, SW_DIV | SW_MET | SW_INC});
        pending_beats.push_back({ST_ESTOP, SW_ALL});
        pending_beats.push_back({ST_ESTOP, SW_NONE});
        pending_beats.push_back({ST_STOPPED, SW_LEAD});
        pending_beats.push_back({ST_STOPPED, SW_LEAD | SW_IMP});
        pending_beats.push_back({ST_STOPPED, SW_LEAD | SW_REV | SW_LHAND});
        pending_beats.push_back({ST_STOPPED, SW_ALL});
        pending_beats.push_back({ST_RUNNING, SW_ALL});
        pending_beats.push_back({ST_STOPPING, SW_NONE});
        run_phase(250, 30, 30);

        // widest limits, largest step
        program_config('{pitch_step: 8'd255, metric_min: 12'd0, metric_max: 12'd4095,
                         imperial_min: 12'd0, imperial_max: 12'd4095});
        run_phase(250, 30, 30);

        // crossed limits, smallest step
        program_config('{pitch_step: 8'd1, metric_min: 12'd4095, metric_max: 12'd0,
                         imperial_min: 12'd3000, imperial_max: 12'd100});
        run_phase(150, 30, 30);

        // random limits, no idling on either side
        program_config(random_cfg());
        run_phase(300, 0, 0);

        program_config(random_cfg());
        run_phase(300, 30, 30);

        // narrow windows near both ends of the range
        program_config('{pitch_step: 8'd200, metric_min: 12'd100, metric_max: 12'd150,
                         imperial_min: 12'd4000, imperial_max: 12'd4095});
        run_phase(200, 30, 30);

        $display("run covered %0d poll beats over %0d register settings, %0d results checked",
                 n_sent, n_configs, n_checked);
        $display("%0d plan requests, %0d run commands, %0d cycles with the input stalled",
                 n_plans, n_runs, n_in_stalls);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
